// File: hdl/lps_pkg.sv
package lps_pkg;

    localparam int MAX_SLOTS  = 4096;
    localparam int SLOT_BITS  = 12;
    localparam int CNT_BITS   = 13;
    localparam int TIME_BITS  = 32;
    localparam int OWNER_BITS = 8;
    localparam int PAGE_BITS  = 24;
    localparam int DIM_BITS   = 7;
    localparam int COL_BITS   = 6;
    localparam int RES_BITS   = 10;
    localparam int PIX_BITS   = 15;
    localparam int WIN_BITS   = 8;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 112;
    localparam int CMD_BITS   = 2;
    localparam int STAT_BITS  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [DIM_BITS-1:0] DIM_MAX = 7'd64;
    localparam logic [RES_BITS-1:0] RES_MAX = 10'd512;

    // commands
    localparam logic [CMD_BITS-1:0] CMD_FRAME  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_TOUCH  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_UPLOAD = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_RESET  = 2'd3;

    // result status
    localparam logic [STAT_BITS-1:0] ST_ACK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_PLACED = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_DUP    = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_THRASH = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd3;

    typedef struct packed {
        logic                  used;
        logic [OWNER_BITS-1:0] owner;
        logic [PAGE_BITS-1:0]  page;
    } slot_info_t;

endpackage

// File: hdl/lru_page_slot_replacer.sv
// LRU page slot replacer.
// Input beats arrive on s_*: s_tuser carries the command, s_tdata the item.
// Every accepted beat yields exactly one result beat on m_*: m_tuser carries
// the status, m_tdata the placed slot, pixel position, evicted page and clock.
// Registers are to be written through cfg_we / cfg_addr / cfg_data only while
// idle; the block itself does not enforce this. Frame start, touch, duplicate
// and discarded uploads pass through S_EXEC and S_DONE to the output register.
// A placing upload scans the slots in use through one table read port, one
// slot per cycle, and stops early when an empty slot turns up. A reset
// command runs a clearing pass over all 4096 slots before its result beat.
// The block takes one beat at a time; s_tready is high only when idle.
// After rst_n the table is cleared by the same clearing pass, during which
// s_tready stays low; register writes are taken throughout.
// When the receiver stalls, the result waits in the output register and the
// block may already take the next beat; its result waits until the first
// one is taken.
module lru_page_slot_replacer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // has_uploads, slot, texture_id, page_index, already_cached, zero pad
    input  logic [lps_pkg::IN_W-1:0]           s_tdata,
    // command
    input  logic [lps_pkg::CMD_BITS-1:0]       s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // phys_slot, pixel_x, pixel_y, evicted_valid, evicted_texture,
    // evicted_page, frame_time, zero pad
    output logic [lps_pkg::OUT_W-1:0]          m_tdata,
    // status
    output logic [lps_pkg::STAT_BITS-1:0]      m_tuser,
    input  logic                               cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [lps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lps_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_SCAN, S_DECIDE, S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [DIM_BITS-1:0] width_cfg_reg, height_cfg_reg;
    logic [RES_BITS-1:0] res_cfg_reg;
    logic [WIN_BITS-1:0] window_reg;

    // control state
    logic [TIME_BITS-1:0] use_clock_reg;
    logic                 frame_open_reg, thrash_reg, clr_reply_reg;
    logic [SLOT_BITS-1:0] clr_idx_reg;

    // latched item
    logic [CMD_BITS-1:0]   cmd_reg;
    logic                  has_up_reg, cached_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [OWNER_BITS-1:0] tex_reg;
    logic [PAGE_BITS-1:0]  page_reg;

    // scan issue side and read pipeline
    logic                  iss_active_reg;
    logic [SLOT_BITS-1:0]  iss_idx_reg;
    logic [COL_BITS-1:0]   iss_col_reg, iss_row_reg;
    logic                  pipe_v_reg;
    logic [SLOT_BITS-1:0]  pipe_idx_reg;
    logic [COL_BITS-1:0]   pipe_col_reg, pipe_row_reg;

    // best candidate
    logic                  first_reg;
    logic                  best_used_reg;
    logic [TIME_BITS-1:0]  best_age_reg;
    logic [SLOT_BITS-1:0]  best_idx_reg;
    logic [COL_BITS-1:0]   best_col_reg, best_row_reg;
    logic [OWNER_BITS-1:0] best_owner_reg;
    logic [PAGE_BITS-1:0]  best_page_reg;

    // pending result
    logic [STAT_BITS-1:0]  r_status_reg;
    logic [SLOT_BITS-1:0]  r_slot_reg;
    logic [PIX_BITS-1:0]   r_px_reg, r_py_reg;
    logic                  r_evv_reg;
    logic [OWNER_BITS-1:0] r_evt_reg;
    logic [PAGE_BITS-1:0]  r_evp_reg;

    // output register
    logic                  m_valid_reg;
    logic [STAT_BITS-1:0]  m_status_reg;
    logic [SLOT_BITS-1:0]  m_slot_reg;
    logic [PIX_BITS-1:0]   m_px_reg, m_py_reg;
    logic                  m_evv_reg;
    logic [OWNER_BITS-1:0] m_evt_reg;
    logic [PAGE_BITS-1:0]  m_evp_reg;
    logic [TIME_BITS-1:0]  m_time_reg;

    // table memories
    logic [TIME_BITS-1:0] time_mem [MAX_SLOTS];
    slot_info_t           info_mem [MAX_SLOTS];
    logic [TIME_BITS-1:0] rd_time_reg;
    slot_info_t           rd_info_reg;

    // geometry
    logic [DIM_BITS-1:0]   w_used, h_used;
    logic [RES_BITS-1:0]   res_used;
    logic [CNT_BITS-1:0]   n_slots;
    logic [TIME_BITS-1:0]  pipe_age;
    logic                  thrash_hit;
    logic [15:0]           px_full, py_full;

    always_comb
    begin
        w_used   = (width_cfg_reg == '0) ? 7'd1 :
                   (width_cfg_reg > DIM_MAX) ? DIM_MAX : width_cfg_reg;
        h_used   = (height_cfg_reg == '0) ? 7'd1 :
                   (height_cfg_reg > DIM_MAX) ? DIM_MAX : height_cfg_reg;
        res_used = (res_cfg_reg == '0) ? 10'd1 :
                   (res_cfg_reg > RES_MAX) ? RES_MAX : res_cfg_reg;
        n_slots  = CNT_BITS'(14'(w_used) * 14'(h_used));
    end

    assign pipe_age   = use_clock_reg - rd_time_reg;
    assign thrash_hit = best_used_reg && (best_age_reg <= TIME_BITS'(window_reg));
    assign px_full    = 16'(best_col_reg) * 16'(res_used);
    assign py_full    = 16'(best_row_reg) * 16'(res_used);

    // table write port
    logic                  tw_we, iw_we;
    logic [SLOT_BITS-1:0]  w_addr;
    logic [TIME_BITS-1:0]  tw_data;
    slot_info_t            iw_data;

    always_comb
    begin
        tw_we   = 1'b0;
        iw_we   = 1'b0;
        w_addr  = best_idx_reg;
        tw_data = use_clock_reg;
        iw_data = '{used: 1'b1, owner: tex_reg, page: page_reg};
        case (state_reg)
            S_CLEAR:
            begin
                tw_we   = 1'b1;
                iw_we   = 1'b1;
                w_addr  = clr_idx_reg;
                tw_data = '0;
                iw_data = '0;
            end
            S_EXEC:
            begin
                w_addr = slot_reg;
                tw_we  = (cmd_reg == CMD_TOUCH) && frame_open_reg &&
                         ({1'b0, slot_reg} < n_slots);
            end
            S_DECIDE:
            begin
                tw_we = !thrash_hit;
                iw_we = !thrash_hit;
            end
            default:
            begin
                tw_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tw_we)
        begin
            time_mem[w_addr] <= tw_data;
        end
        if (iw_we)
        begin
            info_mem[w_addr] <= iw_data;
        end
        rd_time_reg <= time_mem[iss_idx_reg];
        rd_info_reg <= info_mem[iss_idx_reg];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= 7'd64;
            height_cfg_reg <= 7'd64;
            res_cfg_reg    <= 10'd128;
            window_reg     <= 8'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIDTH:  width_cfg_reg  <= cfg_data[DIM_BITS-1:0];
                REG_HEIGHT: height_cfg_reg <= cfg_data[DIM_BITS-1:0];
                REG_RES:    res_cfg_reg    <= cfg_data;
                REG_WINDOW: window_reg     <= cfg_data[WIN_BITS-1:0];
                default:    window_reg     <= window_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            use_clock_reg  <= '0;
            frame_open_reg <= 1'b0;
            thrash_reg     <= 1'b0;
            clr_reply_reg  <= 1'b0;
            clr_idx_reg    <= '0;
            iss_active_reg <= 1'b0;
            pipe_v_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            // S_DONE reloads the output register itself
            if (m_valid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == SLOT_BITS'(MAX_SLOTS - 1))
                    begin
                        state_reg <= clr_reply_reg ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg    <= s_tuser;
                        has_up_reg <= s_tdata[0];
                        slot_reg   <= s_tdata[12:1];
                        tex_reg    <= s_tdata[20:13];
                        page_reg   <= s_tdata[44:21];
                        cached_reg <= s_tdata[45];
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    r_slot_reg   <= '0;
                    r_px_reg     <= '0;
                    r_py_reg     <= '0;
                    r_evv_reg    <= 1'b0;
                    r_evt_reg    <= '0;
                    r_evp_reg    <= '0;
                    case (cmd_reg)
                        CMD_FRAME:
                        begin
                            if (has_up_reg)
                            begin
                                use_clock_reg <= use_clock_reg + 1'b1;
                            end
                            frame_open_reg <= has_up_reg;
                            thrash_reg     <= 1'b0;
                            r_status_reg   <= ST_ACK;
                            state_reg      <= S_DONE;
                        end
                        CMD_UPLOAD:
                        begin
                            if (thrash_reg)
                            begin
                                r_status_reg <= ST_THRASH;
                                state_reg    <= S_DONE;
                            end
                            else if (cached_reg)
                            begin
                                r_status_reg <= ST_DUP;
                                state_reg    <= S_DONE;
                            end
                            else
                            begin
                                iss_active_reg <= 1'b1;
                                iss_idx_reg    <= '0;
                                iss_col_reg    <= '0;
                                iss_row_reg    <= '0;
                                pipe_v_reg     <= 1'b0;
                                first_reg      <= 1'b1;
                                state_reg      <= S_SCAN;
                            end
                        end
                        CMD_RESET:
                        begin
                            use_clock_reg  <= '0;
                            frame_open_reg <= 1'b0;
                            thrash_reg     <= 1'b0;
                            clr_idx_reg    <= '0;
                            clr_reply_reg  <= 1'b1;
                            r_status_reg   <= ST_ACK;
                            state_reg      <= S_CLEAR;
                        end
                        default:
                        begin
                            r_status_reg <= ST_ACK;
                            state_reg    <= S_DONE;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    // issue one read per cycle
                    pipe_v_reg   <= iss_active_reg;
                    pipe_idx_reg <= iss_idx_reg;
                    pipe_col_reg <= iss_col_reg;
                    pipe_row_reg <= iss_row_reg;
                    if (iss_active_reg)
                    begin
                        iss_idx_reg <= iss_idx_reg + 1'b1;
                        if ((CNT_BITS'(iss_idx_reg) + 1'b1) == n_slots)
                        begin
                            iss_active_reg <= 1'b0;
                        end
                        if ((DIM_BITS'(iss_col_reg) + 1'b1) == w_used)
                        begin
                            iss_col_reg <= '0;
                            iss_row_reg <= iss_row_reg + 1'b1;
                        end
                        else
                        begin
                            iss_col_reg <= iss_col_reg + 1'b1;
                        end
                    end
                    // evaluate the slot read last cycle
                    if (pipe_v_reg)
                    begin
                        if (!rd_info_reg.used)
                        begin
                            // empty slot ends the scan; the next upload rearms issue
                            best_used_reg  <= 1'b0;
                            best_idx_reg   <= pipe_idx_reg;
                            best_col_reg   <= pipe_col_reg;
                            best_row_reg   <= pipe_row_reg;
                            state_reg      <= S_DECIDE;
                        end
                        else if (first_reg || (pipe_age > best_age_reg))
                        begin
                            first_reg      <= 1'b0;
                            best_used_reg  <= 1'b1;
                            best_age_reg   <= pipe_age;
                            best_idx_reg   <= pipe_idx_reg;
                            best_col_reg   <= pipe_col_reg;
                            best_row_reg   <= pipe_row_reg;
                            best_owner_reg <= rd_info_reg.owner;
                            best_page_reg  <= rd_info_reg.page;
                        end
                    end
                    else if (!iss_active_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= S_DONE;
                    if (thrash_hit)
                    begin
                        thrash_reg   <= 1'b1;
                        r_status_reg <= ST_THRASH;
                    end
                    else
                    begin
                        r_status_reg <= ST_PLACED;
                        r_slot_reg   <= best_idx_reg;
                        r_px_reg     <= px_full[PIX_BITS-1:0];
                        r_py_reg     <= py_full[PIX_BITS-1:0];
                        r_evv_reg    <= best_used_reg;
                        r_evt_reg    <= best_used_reg ? best_owner_reg : '0;
                        r_evp_reg    <= best_used_reg ? best_page_reg : '0;
                    end
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= r_status_reg;
                        m_slot_reg    <= r_slot_reg;
                        m_px_reg      <= r_px_reg;
                        m_py_reg      <= r_py_reg;
                        m_evv_reg     <= r_evv_reg;
                        m_evt_reg     <= r_evt_reg;
                        m_evp_reg     <= r_evp_reg;
                        m_time_reg    <= use_clock_reg;
                        clr_reply_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'd0, m_time_reg, m_evp_reg, m_evt_reg, m_evv_reg,
                       m_py_reg, m_px_reg, m_slot_reg};

endmodule
